FILE: sv/blsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package blsd_pkg;

    localparam int OP_W   = 3;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;

    localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_RM_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_RM_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_SHOW      = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR     = 3'd5;
    localparam logic [OP_W-1:0] OP_FIND      = 3'd6;
    localparam logic [OP_W-1:0] OP_DELETE    = 3'd7;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd3;

    typedef logic [VAL_W-1:0] val_t;

endpackage

`default_nettype wire

FILE: sv/blsd_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module blsd_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  wire logic           aclk,
    input  wire logic           we,
    input  wire logic [AW-1:0]  wr_addr,
    input  wire blsd_pkg::val_t wr_data,
    input  wire logic           re,
    input  wire logic [AW-1:0]  rd_addr,
    output blsd_pkg::val_t      rd_data
);
    import blsd_pkg::*;

    val_t mem [DEPTH];
    val_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: sv/bounded_list_with_search_delete.sv
// Bounded deque of unsigned 32-bit values with find and delete-by-value.
// Input channel: s_tuser carries the operation code, s_tdata the value.
// Output channel: m_tuser carries the status, m_tdata the value returned,
// m_tlast marks the final result transaction of an operation.
// Every operation yields one result, except show on a non-empty list,
// which yields one result per entry, front first.
// Entries sit in a single-port-write, registered-read RAM of DEPTH words.
// Steps per operation, from acceptance to the result being loaded:
//   insert, clear and the empty/full cases execute directly; remove adds a
//   RAM read; find reads and compares each entry from the front in turn;
//   show reads and sends each entry; delete runs find, then moves each later
//   entry one place toward the front to close the gap, then shrinks the count.
// One operation is in flight at a time; s_tready is high from the edge that
// loads the last result, so the next transaction can land in the next cycle.
// Reset empties the list and drops any pending result; RAM contents are
// not cleared and no clearing pass is needed.
// A stalled receiver holds the output register; the walk waits on it.
`timescale 1ns / 1ps
`default_nettype none

module bounded_list_with_search_delete #(
    parameter int DEPTH = 32
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [blsd_pkg::VAL_W-1:0]   s_tdata,   // value
    input  wire logic [blsd_pkg::OP_W-1:0]    s_tuser,   // operation
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [blsd_pkg::VAL_W-1:0]        m_tdata,   // item_value
    output logic [blsd_pkg::STAT_W-1:0]       m_tuser,   // status
    output logic                              m_tlast
);
    import blsd_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [IW-1:0] LAST_IX = IW'(DEPTH - 1);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_EXEC     = 4'd1;
    localparam logic [3:0] S_RM_WAIT  = 4'd2;
    localparam logic [3:0] S_SCAN_RD  = 4'd3;
    localparam logic [3:0] S_SCAN_CHK = 4'd4;
    localparam logic [3:0] S_SH_RD    = 4'd5;
    localparam logic [3:0] S_SH_WR    = 4'd6;
    localparam logic [3:0] S_OUT      = 4'd7;

    logic [3:0]        state_reg, state_next;
    logic [IW-1:0]     front_reg, front_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [OP_W-1:0]   op_reg, op_next;
    val_t              val_reg, val_next;
    logic [STAT_W-1:0] res_stat_reg, res_stat_next;
    val_t              res_val_reg, res_val_next;
    logic              m_valid_reg, m_valid_next;
    logic [STAT_W-1:0] m_stat_reg, m_stat_next;
    val_t              m_val_reg, m_val_next;
    logic              m_last_reg, m_last_next;

    logic              we, re;
    logic [IW-1:0]     wr_addr, rd_addr;
    val_t              wr_data, rd_data;
    logic              out_free;
    logic [CW-1:0]     idx_inc;
    logic [IW-1:0]     front_dec, front_inc;

    function automatic logic [IW-1:0] slot(input logic [IW-1:0] base,
                                           input logic [CW-1:0] off);
        logic [SW-1:0] s;
        s = SW'(base) + SW'(off);
        if (s >= SW'(DEPTH)) begin
            s = s - SW'(DEPTH);
        end
        return s[IW-1:0];
    endfunction

    blsd_ram #(
        .DEPTH (DEPTH),
        .AW    (IW)
    ) u_ram (
        .aclk    (aclk),
        .we      (we),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .re      (re),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_free  = !m_valid_reg || m_tready;
    assign idx_inc   = idx_reg + CW'(1);
    assign front_dec = (front_reg == '0) ? LAST_IX : front_reg - IW'(1);
    assign front_inc = (front_reg == LAST_IX) ? '0 : front_reg + IW'(1);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_val_reg;
    assign m_tuser  = m_stat_reg;
    assign m_tlast  = m_last_reg;

    always_comb begin
        state_next    = state_reg;
        front_next    = front_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        op_next       = op_reg;
        val_next      = val_reg;
        res_stat_next = res_stat_reg;
        res_val_next  = res_val_reg;
        m_valid_next  = m_valid_reg;
        m_stat_next   = m_stat_reg;
        m_val_next    = m_val_reg;
        m_last_next   = m_last_reg;
        we            = 1'b0;
        wr_addr       = slot(front_reg, idx_reg);
        wr_data       = val_reg;
        re            = 1'b0;
        rd_addr       = slot(front_reg, idx_reg);

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next    = s_tuser;
                    val_next   = s_tdata;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                res_stat_next = STAT_OK;
                res_val_next  = '0;
                idx_next      = '0;
                state_next    = S_OUT;
                case (op_reg)
                    OP_INS_FRONT, OP_INS_BACK: begin
                        if (count_reg == DEPTH_C) begin
                            res_stat_next = STAT_FULL;
                        end else begin
                            we         = 1'b1;
                            count_next = count_reg + CW'(1);
                            if (op_reg == OP_INS_FRONT) begin
                                wr_addr    = front_dec;
                                front_next = front_dec;
                            end else begin
                                wr_addr = slot(front_reg, count_reg);
                            end
                        end
                    end
                    OP_RM_FRONT, OP_RM_BACK: begin
                        if (count_reg == '0) begin
                            res_stat_next = STAT_EMPTY;
                        end else begin
                            re         = 1'b1;
                            count_next = count_reg - CW'(1);
                            state_next = S_RM_WAIT;
                            if (op_reg == OP_RM_FRONT) begin
                                rd_addr    = front_reg;
                                front_next = front_inc;
                            end else begin
                                rd_addr = slot(front_reg, count_reg - CW'(1));
                            end
                        end
                    end
                    OP_CLEAR: begin
                        front_next = '0;
                        count_next = '0;
                    end
                    default: begin
                        if (count_reg == '0) begin
                            res_stat_next = STAT_EMPTY;
                        end else begin
                            state_next = S_SCAN_RD;
                        end
                    end
                endcase
            end
            S_RM_WAIT: begin
                res_val_next = rd_data;
                state_next   = S_OUT;
            end
            S_SCAN_RD: begin
                re         = 1'b1;
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (op_reg == OP_SHOW) begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_stat_next  = STAT_OK;
                        m_val_next   = rd_data;
                        m_last_next  = (idx_inc == count_reg);
                        if (idx_inc == count_reg) begin
                            state_next = S_IDLE;
                        end else begin
                            idx_next   = idx_inc;
                            state_next = S_SCAN_RD;
                        end
                    end
                end else if (rd_data == val_reg) begin
                    res_stat_next = STAT_OK;
                    res_val_next  = rd_data;
                    state_next    = (op_reg == OP_DELETE) ? S_SH_RD : S_OUT;
                end else if (idx_inc == count_reg) begin
                    res_stat_next = STAT_NOTFOUND;
                    res_val_next  = '0;
                    state_next    = S_OUT;
                end else begin
                    idx_next   = idx_inc;
                    state_next = S_SCAN_RD;
                end
            end
            S_SH_RD: begin
                if (idx_inc < count_reg) begin
                    re         = 1'b1;
                    rd_addr    = slot(front_reg, idx_inc);
                    state_next = S_SH_WR;
                end else begin
                    count_next = count_reg - CW'(1);
                    state_next = S_OUT;
                end
            end
            S_SH_WR: begin
                we         = 1'b1;
                wr_data    = rd_data;
                idx_next   = idx_inc;
                state_next = S_SH_RD;
            end
            S_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_stat_next  = res_stat_reg;
                    m_val_next   = res_val_reg;
                    m_last_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            front_reg   <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            front_reg   <= front_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        op_reg       <= op_next;
        val_reg      <= val_next;
        res_stat_reg <= res_stat_next;
        res_val_reg  <= res_val_next;
        m_stat_reg   <= m_stat_next;
        m_val_reg    <= m_val_next;
        m_last_reg   <= m_last_next;
    end

endmodule

`default_nettype wire
